/* rtl/apsj_pkg.sv */
`timescale 1ns / 1ps
package apsj_pkg;

  localparam int TS_W        = 32;
  localparam int CLK_HZ_W    = 20;
  localparam int AUDIO_HZ_W  = 18;
  localparam int MS_CFG_W    = 14;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 20;

  localparam int DIVIDEND_W  = 42;
  localparam int DIV_STEPS   = DIVIDEND_W;
  localparam int DIV_CNT_W   = 6;
  localparam int MEDIA_W     = 43;
  localparam int CE_W        = 34;
  localparam int SLACK_W     = 44;

  localparam int AUDIO_REBASE_MS = 10000;
  localparam int VIDEO_REBASE_MS = 10000;
  localparam int RUN_LIMIT       = 10;

  localparam logic [1:0] OP_AUDIO   = 2'd0;
  localparam logic [1:0] OP_VIDEO   = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] REG_SCALE_MODE     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_AUDIO_CLOCK_HZ = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_VIDEO_CLOCK_HZ = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_AUDIO_CACHE_MS = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_VIDEO_CACHE_MS = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_AUDIO_MAX_MS   = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_VIDEO_MAX_MS   = 3'd6;

  typedef enum logic [1:0] {
    VERDICT_PLAY = 2'd0,
    VERDICT_HOLD = 2'd1,
    VERDICT_LATE = 2'd2
  } verdict_e;

  typedef struct packed {
    logic [TS_W-1:0] abase;
    logic [TS_W-1:0] vbase;
    logic [TS_W-1:0] astart;
    logic [TS_W-1:0] vstart;
    logic            abased;
    logic            vbased;
    logic            aseen;
    logic            vseen;
    logic            ksync;
    logic [3:0]      late_run;
    logic [3:0]      early_run;
  } sync_state_t;

endpackage

/* rtl/apsj_div.sv */
`timescale 1ns / 1ps
module apsj_div import apsj_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [CLK_HZ_W-1:0]   divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic [CLK_HZ_W-1:0]   rem_q, rem_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [CLK_HZ_W-1:0]   dvs_q, dvs_d;

  logic [CLK_HZ_W:0] shifted;
  logic [CLK_HZ_W:0] trial;
  logic              fits;

  assign shifted = {rem_q, quo_q[DIVIDEND_W-1]};
  assign trial   = shifted - {1'b0, dvs_q};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIV_STEPS - 1);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // one restoring step per cycle
      rem_d = fits ? trial[CLK_HZ_W-1:0] : shifted[CLK_HZ_W-1:0];
      quo_d = {quo_q[DIVIDEND_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* rtl/av_playout_sync_judge.sv */
`timescale 1ns / 1ps
// audio/video playout sync judge
// slave stream: one request per frame or audio clock restart; tuser carries the
// opcode and the keyframe flag, tdata the media timestamp and the wall clock
// master stream: one result per request with verdict, flush flag and slack
// config channel: register index and data, always ready, to be written while
// idle (the block does not enforce this); a scaled frame passes base, multiply,
// divide, judge and emit states, the bit-serial divider giving one quotient bit
// per cycle over 42 bits; an unscaled frame skips divide, and a first frame,
// restart or unused opcode goes from base straight to emit; one request is in
// work at a time; s_axis_tready is high only while idle, so a new request is
// taken only after the last one has left emit; the result sits in an output
// register, so the next request is accepted and worked on while the receiver
// stalls; a finished result waits in emit until the receiver takes the previous
// one; reset clears all stream state and loads the register defaults
module av_playout_sync_judge import apsj_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [63:0]           s_axis_tdata,  // timestamp, now_ms
  input  logic [2:0]            s_axis_tuser,  // opcode, is_keyframe
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [31:0]           m_axis_tdata,  // slack_ms
  output logic [2:0]            m_axis_tuser   // verdict, flush_request
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_BASE  = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_JUDGE = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0] state_q, state_d;

  logic                  scale_q;
  logic [AUDIO_HZ_W-1:0] aclk_q;
  logic [CLK_HZ_W-1:0]   vclk_q;
  logic [MS_CFG_W-1:0]   acache_q, vcache_q, amax_q, vmax_q;

  sync_state_t st_q, st_d;

  logic [1:0]      op_q, op_d;
  logic [TS_W-1:0] ts_q, ts_d;
  logic            key_q, key_d;
  logic [TS_W-1:0] now_q, now_d;

  logic                      neg_q, neg_d;
  logic signed [CE_W-1:0]    ce_q, ce_d;
  logic signed [MEDIA_W-1:0] media_q, media_d;
  verdict_e                  verdict_q, verdict_d;
  logic                      flush_q, flush_d;
  logic [31:0]               slack_q, slack_d;

  logic        m_valid_q, m_valid_d;
  verdict_e    m_verdict_q, m_verdict_d;
  logic        m_flush_q, m_flush_d;
  logic [31:0] m_slack_q, m_slack_d;

  logic                  div_start;
  logic                  div_done;
  logic [DIVIDEND_W-1:0] div_quo;

  logic                   is_video;
  logic [TS_W-1:0]        base_sel, start_sel, elapsed;
  logic [MS_CFG_W-1:0]    cache_sel, max_sel;
  logic [CLK_HZ_W-1:0]    clk_sel;
  logic [TS_W:0]          diff;
  logic [TS_W-1:0]        mag;
  logic [DIVIDEND_W-1:0]  prod;
  logic signed [CE_W-1:0] ce_calc;

  logic signed [SLACK_W-1:0] slack;
  logic                      is_late, is_play, media_big_a, media_big_v;
  logic [31:0]               slack_sat;
  logic                      rebase_a;

  assign is_video  = (op_q == OP_VIDEO);
  assign base_sel  = is_video ? st_q.vbase  : st_q.abase;
  assign start_sel = is_video ? st_q.vstart : st_q.astart;
  assign cache_sel = is_video ? vcache_q    : acache_q;
  assign max_sel   = is_video ? vmax_q      : amax_q;
  assign clk_sel   = is_video ? vclk_q      : {{(CLK_HZ_W-AUDIO_HZ_W){1'b0}}, aclk_q};

  assign diff    = {1'b0, ts_q} - {1'b0, base_sel};
  assign mag     = diff[TS_W] ? TS_W'(-diff) : diff[TS_W-1:0];
  // times 1000 as 1024 - 16 - 8
  assign prod    = {mag, 10'b0} - {6'b0, mag, 4'b0} - {7'b0, mag, 3'b0};
  assign elapsed = now_q - start_sel;
  assign ce_calc = $signed({{(CE_W-MS_CFG_W){1'b0}}, cache_sel})
                 - $signed({2'b0, elapsed});

  assign slack       = {media_q[MEDIA_W-1], media_q}
                     + {{(SLACK_W-CE_W){ce_q[CE_W-1]}}, ce_q};
  assign is_late     = slack[SLACK_W-1];
  assign is_play     = !is_late && (slack <= $signed({{(SLACK_W-MS_CFG_W){1'b0}}, max_sel}));
  assign media_big_a = media_q > $signed(MEDIA_W'(AUDIO_REBASE_MS));
  assign media_big_v = media_q > $signed(MEDIA_W'(VIDEO_REBASE_MS));

  always_comb begin
    if ((&slack[SLACK_W-1:31]) || !(|slack[SLACK_W-1:31])) begin
      slack_sat = slack[31:0];
    end else if (slack[SLACK_W-1]) begin
      slack_sat = 32'h8000_0000;
    end else begin
      slack_sat = 32'h7fff_ffff;
    end
  end

  apsj_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod),
    .divisor_i  (clk_sel),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    state_d     = state_q;
    st_d        = st_q;
    op_d        = op_q;
    ts_d        = ts_q;
    key_d       = key_q;
    now_d       = now_q;
    neg_d       = neg_q;
    ce_d        = ce_q;
    media_d     = media_q;
    verdict_d   = verdict_q;
    flush_d     = flush_q;
    slack_d     = slack_q;
    m_valid_d   = m_valid_q;
    m_verdict_d = m_verdict_q;
    m_flush_d   = m_flush_q;
    m_slack_d   = m_slack_q;
    div_start   = 1'b0;
    rebase_a    = 1'b0;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          op_d    = s_axis_tuser[1:0];
          key_d   = s_axis_tuser[2];
          ts_d    = s_axis_tdata[31:0];
          now_d   = s_axis_tdata[63:32];
          state_d = ST_BASE;
        end
      end
      ST_BASE: begin
        verdict_d = VERDICT_PLAY;
        flush_d   = 1'b0;
        slack_d   = '0;
        case (op_q)
          OP_AUDIO: begin
            if (!st_q.abased && !st_q.aseen) begin
              st_d.aseen = 1'b1;
              verdict_d  = VERDICT_HOLD;
              flush_d    = 1'b1;
              state_d    = ST_EMIT;
            end else begin
              if (!st_q.abased) begin
                st_d.abase  = ts_q;
                st_d.astart = now_q;
                st_d.abased = 1'b1;
              end
              state_d = ST_MUL;
            end
          end
          OP_VIDEO: begin
            if (!st_q.vbased && !st_q.vseen) begin
              st_d.vseen = 1'b1;
              verdict_d  = VERDICT_HOLD;
              flush_d    = 1'b1;
              state_d    = ST_EMIT;
            end else begin
              if (!st_q.vbased) begin
                st_d.vbase  = ts_q;
                st_d.vstart = now_q;
                st_d.vbased = 1'b1;
              end
              if (!st_q.ksync && key_q) begin
                st_d.vbase  = ts_q;
                st_d.vstart = now_q;
                st_d.ksync  = 1'b1;
              end
              state_d = ST_MUL;
            end
          end
          OP_RESTART: begin
            st_d.astart = now_q;
            state_d     = ST_EMIT;
          end
          default: begin
            state_d = ST_EMIT;
          end
        endcase
      end
      ST_MUL: begin
        ce_d  = ce_calc;
        neg_d = diff[TS_W];
        if (scale_q) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end else begin
          media_d = $signed({{(MEDIA_W-TS_W-1){diff[TS_W]}}, diff});
          state_d = ST_JUDGE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          media_d = neg_q ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
          state_d = ST_JUDGE;
        end
      end
      ST_JUDGE: begin
        flush_d = 1'b0;
        slack_d = slack_sat;
        if (is_late) begin
          verdict_d = VERDICT_LATE;
        end else if (is_play) begin
          verdict_d = VERDICT_PLAY;
        end else begin
          verdict_d = VERDICT_HOLD;
        end
        if (is_video) begin
          if (media_big_v && key_q) begin
            st_d.vbase  = ts_q;
            st_d.vstart = now_q;
          end
        end else begin
          rebase_a = media_big_a;
          if (is_late) begin
            if (({1'b0, st_q.late_run} + 5'd1) > 5'(RUN_LIMIT)) begin
              st_d.late_run = '0;
              rebase_a      = 1'b1;
            end else begin
              st_d.late_run = st_q.late_run + 4'd1;
            end
          end else if (!is_play) begin
            if (({1'b0, st_q.early_run} + 5'd1) > 5'(RUN_LIMIT)) begin
              st_d.early_run = '0;
              rebase_a       = 1'b1;
            end else begin
              st_d.early_run = st_q.early_run + 4'd1;
            end
          end
          if (rebase_a) begin
            st_d.abase  = ts_q;
            st_d.astart = now_q;
          end
        end
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d   = 1'b1;
          m_verdict_d = verdict_q;
          m_flush_d   = flush_q;
          m_slack_d   = slack_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      st_q      <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      st_q      <= st_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    ts_q        <= ts_d;
    key_q       <= key_d;
    now_q       <= now_d;
    neg_q       <= neg_d;
    ce_q        <= ce_d;
    media_q     <= media_d;
    verdict_q   <= verdict_d;
    flush_q     <= flush_d;
    slack_q     <= slack_d;
    m_verdict_q <= m_verdict_d;
    m_flush_q   <= m_flush_d;
    m_slack_q   <= m_slack_d;
  end

  // register file, zero clock rates are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= 1'b1;
      aclk_q   <= AUDIO_HZ_W'(48000);
      vclk_q   <= CLK_HZ_W'(90000);
      acache_q <= '0;
      vcache_q <= '0;
      amax_q   <= MS_CFG_W'(100);
      vmax_q   <= MS_CFG_W'(100);
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        REG_SCALE_MODE:     scale_q  <= cfg_data_i[0];
        REG_AUDIO_CLOCK_HZ: begin
          if (cfg_data_i[AUDIO_HZ_W-1:0] != '0) aclk_q <= cfg_data_i[AUDIO_HZ_W-1:0];
        end
        REG_VIDEO_CLOCK_HZ: begin
          if (cfg_data_i[CLK_HZ_W-1:0] != '0) vclk_q <= cfg_data_i[CLK_HZ_W-1:0];
        end
        REG_AUDIO_CACHE_MS: acache_q <= cfg_data_i[MS_CFG_W-1:0];
        REG_VIDEO_CACHE_MS: vcache_q <= cfg_data_i[MS_CFG_W-1:0];
        REG_AUDIO_MAX_MS:   amax_q   <= cfg_data_i[MS_CFG_W-1:0];
        REG_VIDEO_MAX_MS:   vmax_q   <= cfg_data_i[MS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_slack_q;
  assign m_axis_tuser  = {m_flush_q, m_verdict_q};

endmodule

/* rtl/apsj_checker.sv */
`timescale 1ns / 1ps
module apsj_checker import apsj_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while a request is in work");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_flush_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2] |->
      m_axis_tuser[1:0] == VERDICT_HOLD && m_axis_tdata == '0)
    else $error("flush result not hold with zero slack");

  a_verdict_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser[1:0] != 2'd3)
    else $error("verdict code out of range");

  a_late_negative: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1:0] == VERDICT_LATE |-> m_axis_tdata[31])
    else $error("late verdict with non-negative slack");

endmodule

bind av_playout_sync_judge apsj_checker u_apsj_checker (.*);
